>>> hw/rtl/lec_pkg.sv
// ----------------------------------------------------------------------------
// lec_pkg
// shared constants, key codes, sequencer states and the result record
// for the line editor
// ----------------------------------------------------------------------------
package lec_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int ROW_WIDTH_DEF   = 64;
  localparam int WINDOW_ROWS_DEF = 2;

  localparam logic [7:0] KEY_ENTER  = 8'd10;
  localparam logic [7:0] KEY_BACK   = 8'd8;
  localparam logic [7:0] KEY_LEFT   = 8'd27;
  localparam logic [7:0] KEY_RIGHT  = 8'd91;
  localparam logic [7:0] SPACE_CHAR = 8'd32;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_WAIT,
    S_BACK,
    S_BZERO,
    S_INS,
    S_INSKEY,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [7:0] cursor_position;
    logic [7:0] window_start;
    logic       view_row;
    logic [5:0] cursor_column;
    logic [7:0] fetched_char;
    logic       key_applied;
  } result_t;

endpackage

>>> hw/rtl/lec_store.sv
// ----------------------------------------------------------------------------
// lec_store
// line store: one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module lec_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/lec_seq.sv
// ----------------------------------------------------------------------------
// lec_seq
// edit sequencer: decodes an item, walks the line store for clears and
// shifts, keeps the cursor with its row and column, forms the result
// ----------------------------------------------------------------------------
module lec_seq #(
  parameter int STORE_DEPTH = 256,
  parameter int ROW_WIDTH   = 64,
  parameter int WINDOW_ROWS = 2,
  parameter int CW          = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [7:0]        in_key_code,
  input  logic [6:0]        in_window_offset,
  output logic              wr_en,
  output logic [CW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [CW-1:0]     rd_addr,
  input  logic [7:0]        rd_data,
  input  logic              out_free,
  output logic              res_load,
  output lec_pkg::result_t  res
);

  import lec_pkg::*;

  localparam int ROWS_MAX     = (STORE_DEPTH - 1) / ROW_WIDTH + 1;
  localparam int RIW          = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int COLW         = $clog2(ROW_WIDTH);
  localparam int SW_A         = RIW + $clog2(ROW_WIDTH + 1);
  localparam int SW           = (SW_A > CW) ? SW_A : CW;
  localparam int IW           = ((CW > 7) ? CW : 7) + 1;
  localparam int WINDOW_CHARS = ROW_WIDTH * WINDOW_ROWS;
  localparam logic [CW-1:0] LAST = CW'(STORE_DEPTH - 1);

  seq_state_t     state_r, state_nxt;
  logic [CW-1:0]  cursor_r, cursor_nxt;
  logic [RIW-1:0] row_r, row_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [CW-1:0]  addr_r, addr_nxt;
  logic [7:0]     key_r, key_nxt;
  logic           fetch_r, fetch_nxt;
  logic [7:0]     fetched_r, fetched_nxt;
  logic           applied_r, applied_nxt;

  logic           cur_zero, cur_last;
  logic [RIW-1:0] row_inc, row_dec;
  logic [COLW-1:0] col_inc, col_dec;
  logic           in_window;
  logic [RIW-1:0] win_row;
  logic [RIW-1:0] row_sub;
  logic [SW-1:0]  start_wide;
  logic [CW-1:0]  start;
  logic [IW-1:0]  fetch_idx;
  logic           fetch_oob;
  logic [CW+7:0]  cur_ext, start_ext;
  logic [COLW+5:0] col_ext;

  assign cur_zero = (cursor_r == '0);
  assign cur_last = (cursor_r == LAST);

  // cursor neighbours in row and column form
  always_comb begin
    if (col_r == COLW'(ROW_WIDTH - 1)) begin
      col_inc = '0;
      row_inc = row_r + 1'b1;
    end else begin
      col_inc = col_r + 1'b1;
      row_inc = row_r;
    end
    if (col_r == '0) begin
      col_dec = COLW'(ROW_WIDTH - 1);
      row_dec = row_r - 1'b1;
    end else begin
      col_dec = col_r - 1'b1;
      row_dec = row_r;
    end
  end

  // window scrolls by whole rows
  assign in_window  = (32'(row_r) < 32'(WINDOW_ROWS));
  assign row_sub    = row_r - RIW'(WINDOW_ROWS - 1);
  assign start_wide = in_window ? '0 : (SW'(row_sub) * SW'(ROW_WIDTH));
  assign start      = start_wide[CW-1:0];
  assign win_row    = in_window ? row_r : RIW'(WINDOW_ROWS - 1);

  assign fetch_idx = IW'(start) + IW'(in_window_offset);
  assign fetch_oob = (32'(in_window_offset) >= 32'(WINDOW_CHARS)) ||
                     (fetch_idx >= IW'(STORE_DEPTH));

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (addr_r == LAST) state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        if (addr_r == LAST) state_nxt = S_DONE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_command) begin
            state_nxt = fetch_oob ? S_DONE : S_WAIT;
          end else begin
            case (in_key_code)
              KEY_ENTER: state_nxt = S_CLEAR;
              KEY_BACK:  state_nxt = cur_zero ? S_DONE : S_BACK;
              KEY_LEFT:  state_nxt = S_DONE;
              KEY_RIGHT: state_nxt = cur_last ? S_DONE : S_WAIT;
              default:   state_nxt = cur_last ? S_DONE : S_INS;
            endcase
          end
        end
      end
      S_WAIT:   state_nxt = S_DONE;
      S_BACK: begin
        if (addr_r == LAST) state_nxt = S_BZERO;
      end
      S_BZERO:  state_nxt = S_DONE;
      S_INS: begin
        if (addr_r == cursor_r) state_nxt = S_INSKEY;
      end
      S_INSKEY: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cursor_nxt  = cursor_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    addr_nxt    = addr_r;
    key_nxt     = key_r;
    fetch_nxt   = fetch_r;
    fetched_nxt = fetched_r;
    applied_nxt = applied_r;
    wr_en       = 1'b0;
    wr_addr     = addr_r;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = cursor_r;
    res_load    = 1'b0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = addr_r;
        addr_nxt = addr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt     = in_key_code;
          fetch_nxt   = in_command;
          fetched_nxt = '0;
          applied_nxt = 1'b0;
          if (in_command) begin
            if (fetch_oob) begin
              fetched_nxt = SPACE_CHAR;
            end else begin
              rd_en   = 1'b1;
              rd_addr = fetch_idx[CW-1:0];
            end
          end else begin
            case (in_key_code)
              KEY_ENTER: begin
                applied_nxt = 1'b1;
                cursor_nxt  = '0;
                row_nxt     = '0;
                col_nxt     = '0;
                addr_nxt    = '0;
              end
              KEY_BACK: begin
                if (!cur_zero) begin
                  applied_nxt = 1'b1;
                  cursor_nxt  = cursor_r - 1'b1;
                  row_nxt     = row_dec;
                  col_nxt     = col_dec;
                  rd_en       = 1'b1;
                  rd_addr     = cursor_r;
                  addr_nxt    = cursor_r;
                end
              end
              KEY_LEFT: begin
                if (!cur_zero) begin
                  applied_nxt = 1'b1;
                  cursor_nxt  = cursor_r - 1'b1;
                  row_nxt     = row_dec;
                  col_nxt     = col_dec;
                end
              end
              KEY_RIGHT: begin
                if (!cur_last) begin
                  rd_en   = 1'b1;
                  rd_addr = cursor_r;
                end
              end
              default: begin
                if (!cur_last) begin
                  rd_en    = 1'b1;
                  rd_addr  = LAST - 1'b1;
                  addr_nxt = LAST - 1'b1;
                end
              end
            endcase
          end
        end
      end
      S_WAIT: begin
        if (fetch_r) begin
          fetched_nxt = rd_data;
        end else if (rd_data != '0) begin
          applied_nxt = 1'b1;
          cursor_nxt  = cursor_r + 1'b1;
          row_nxt     = row_inc;
          col_nxt     = col_inc;
        end
      end
      S_BACK: begin
        // tail moves one place left
        wr_en   = 1'b1;
        wr_addr = addr_r - 1'b1;
        wr_data = rd_data;
        if (addr_r != LAST) begin
          rd_en    = 1'b1;
          rd_addr  = addr_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_BZERO: begin
        wr_en   = 1'b1;
        wr_addr = LAST;
      end
      S_INS: begin
        // tail moves one place right, last byte drops
        wr_en   = 1'b1;
        wr_addr = addr_r + 1'b1;
        wr_data = rd_data;
        if (addr_r != cursor_r) begin
          rd_en    = 1'b1;
          rd_addr  = addr_r - 1'b1;
          addr_nxt = addr_r - 1'b1;
        end
      end
      S_INSKEY: begin
        wr_en       = 1'b1;
        wr_addr     = cursor_r;
        wr_data     = key_r;
        applied_nxt = 1'b1;
        cursor_nxt  = cursor_r + 1'b1;
        row_nxt     = row_inc;
        col_nxt     = col_inc;
      end
      S_DONE: begin
        res_load = out_free;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  assign cur_ext   = {8'b0, cursor_r};
  assign start_ext = {8'b0, start};
  assign col_ext   = {6'b0, col_r};

  always_comb begin
    res.cursor_position = cur_ext[7:0];
    res.window_start    = start_ext[7:0];
    res.view_row        = win_row[0];
    res.cursor_column   = col_ext[5:0];
    res.fetched_char    = fetched_r;
    res.key_applied     = applied_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      cursor_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      addr_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      addr_r   <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    fetch_r   <= fetch_nxt;
    fetched_r <= fetched_nxt;
    applied_r <= applied_nxt;
  end

endmodule

>>> hw/rtl/lec_out.sv
// ----------------------------------------------------------------------------
// lec_out
// result register: holds one finished result until the transfer
// ----------------------------------------------------------------------------
module lec_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lec_pkg::result_t  res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output lec_pkg::result_t  out_res
);

  import lec_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> hw/rtl/line_editor_with_cursor.sv
// ----------------------------------------------------------------------------
// line_editor_with_cursor
// line-edit buffer with a cursor and a two-row scrolling display window
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. A fetch or a right key
// makes one store read; a left key, and a key or fetch settled without the
// store, needs none. Backspace walks the tail of the line store one entry a
// cycle; insert walks it the same way, from the end down to the cursor;
// enter clears the whole store. After reset the store is cleared by the same
// pass, with in_tready low. The store has a single read and a single write
// port. A finished result waits in its own register, so the next item is
// taken while it is still unread.
// ----------------------------------------------------------------------------
module line_editor_with_cursor #(
  parameter int STORE_DEPTH = lec_pkg::STORE_DEPTH_DEF,
  parameter int ROW_WIDTH   = lec_pkg::ROW_WIDTH_DEF,
  parameter int WINDOW_ROWS = lec_pkg::WINDOW_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // key_code, window_offset
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // cursor_position, window_start, view_row,
                                  // cursor_column, fetched_char, key_applied
);

  import lec_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH);

  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          out_free;
  logic          res_load;
  result_t       res;
  result_t       out_res;

  lec_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (CW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lec_seq #(
    .STORE_DEPTH (STORE_DEPTH),
    .ROW_WIDTH   (ROW_WIDTH),
    .WINDOW_ROWS (WINDOW_ROWS),
    .CW          (CW)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_command       (in_tuser),
    .in_key_code      (in_tdata[7:0]),
    .in_window_offset (in_tdata[14:8]),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_free         (out_free),
    .res_load         (res_load),
    .res              (res)
  );

  lec_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.key_applied, out_res.fetched_char, out_res.cursor_column,
                      out_res.view_row, out_res.window_start, out_res.cursor_position};

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the line editor: keys and window fetches go in as
// stream transfers, and a local model of the line store, cursor and scrolling
// window predicts each status word, which is compared field by field
// ----------------------------------------------------------------------------
module tb;
  import lec_pkg::*;

  localparam int DEPTH      = STORE_DEPTH_DEF;
  localparam int ROW_W      = ROW_WIDTH_DEF;
  localparam int ROWS       = WINDOW_ROWS_DEF;
  localparam int STALL_MAX  = 4000;
  localparam int PRINT_MAX  = 60;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  line_editor_with_cursor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  logic [7:0]  line_mem [DEPTH];
  int unsigned caret;
  result_t     awaited_status [$];
  int          mismatches;
  int          status_seen;
  int          quiet_cycles;
  bit          sender_idles;
  bit          receiver_stalls;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // model of the editor: applies one item and gives the status word it yields
  function automatic result_t edit_and_view(bit fetch, logic [7:0] key, logic [6:0] offset);
    result_t     r;
    int unsigned start;
    int unsigned idx;
    bit          applied;
    applied = 1'b0;
    if (!fetch) begin
      case (key)
        KEY_ENTER: begin
          for (int i = 0; i < DEPTH; i++) line_mem[i] = 8'd0;
          caret   = 0;
          applied = 1'b1;
        end
        KEY_BACK: begin
          if (caret != 0) begin
            caret--;
            for (int i = caret; i < DEPTH - 1; i++) line_mem[i] = line_mem[i + 1];
            line_mem[DEPTH - 1] = 8'd0;
            applied = 1'b1;
          end
        end
        KEY_LEFT: begin
          if (caret != 0) begin
            caret--;
            applied = 1'b1;
          end
        end
        KEY_RIGHT: begin
          if (caret < DEPTH - 1 && line_mem[caret] != 8'd0) begin
            caret++;
            applied = 1'b1;
          end
        end
        default: begin
          if (caret < DEPTH - 1) begin
            for (int i = DEPTH - 1; i > caret; i--) line_mem[i] = line_mem[i - 1];
            line_mem[caret] = key;
            caret++;
            applied = 1'b1;
          end
        end
      endcase
    end
    start = (caret < ROW_W * ROWS) ? 0 : (caret / ROW_W - (ROWS - 1)) * ROW_W;
    r.fetched_char = 8'd0;
    if (fetch) begin
      idx = start + offset;
      if (offset >= ROW_W * ROWS || idx >= DEPTH) r.fetched_char = SPACE_CHAR;
      else r.fetched_char = line_mem[idx];
    end
    r.cursor_position = caret[7:0];
    r.window_start    = start[7:0];
    r.view_row        = 1'(caret / ROW_W - start / ROW_W);
    r.cursor_column   = 6'(caret % ROW_W);
    r.key_applied     = applied;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < PRINT_MAX) $display("mismatch at status %0d: %s", status_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // one transfer in; in_tvalid stays high afterwards so back-to-back items need no gap
  task automatic present_item(bit fetch, logic [7:0] key, logic [6:0] offset);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fetch;
    in_tdata  <= {1'b0, offset, key};
    do @(posedge clk); while (!in_tready);
    awaited_status.push_back(edit_and_view(fetch, key, offset));
  endtask

  task automatic press(logic [7:0] key);
    present_item(1'b0, key, 7'($urandom_range(0, 127)));
  endtask

  task automatic fetch_at(logic [6:0] offset);
    present_item(1'b1, 8'($urandom_range(0, 255)), offset);
  endtask

  function automatic logic [7:0] text_key();
    logic [7:0] k;
    do k = 8'($urandom_range(0, 255));
    while (k == KEY_ENTER || k == KEY_BACK || k == KEY_LEFT || k == KEY_RIGHT);
    return k;
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 199);
    if (r == 0) press(KEY_ENTER);
    else if (r <= 50) fetch_at(7'($urandom_range(0, 127)));
    else if (r <= 65) press(KEY_LEFT);
    else if (r <= 80) press(KEY_RIGHT);
    else if (r <= 95) press(KEY_BACK);
    else press(text_key());
  endtask

  task automatic test_empty_line();
    fetch_at(7'd0);
    fetch_at(7'd127);
    press(KEY_BACK);
    press(KEY_LEFT);
    press(KEY_RIGHT);
  endtask

  task automatic test_edit_keys();
    press(8'd65);
    press(8'd0);
    press(8'd255);
    press(KEY_LEFT);
    press(KEY_LEFT);
    press(KEY_RIGHT);
    press(KEY_LEFT);
    press(KEY_RIGHT);
    press(KEY_BACK);
    fetch_at(7'd0);
    fetch_at(7'd1);
    fetch_at(7'd2);
    fetch_at(7'd64);
    press(KEY_ENTER);
    fetch_at(7'd0);
  endtask

  // fill the line until the cursor reaches the last slot, then probe the refused insert and the far window
  task automatic test_full_line();
    press(KEY_ENTER);
    while (caret < DEPTH - 1) press(text_key());
    press(text_key());
    press(KEY_RIGHT);
    fetch_at(7'd0);
    fetch_at(7'd63);
    fetch_at(7'd64);
    fetch_at(7'd127);
    repeat (3) press(KEY_LEFT);
    press(KEY_RIGHT);
    press(KEY_BACK);
    repeat (70) press(KEY_LEFT);
    fetch_at(7'd5);
    press(KEY_BACK);
    press(8'd0);
    press(KEY_ENTER);
  endtask

  task automatic test_random_edits(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) begin
        repeat ($urandom_range(20, 80)) press(text_key());
      end
      else random_item();
    end
  endtask

  task automatic test_back_to_back(int count);
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    for (int n = 0; n < count; n++) random_item();
  endtask

  // sink side with bursts of back-pressure
  initial begin
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cursor_position = out_tdata[7:0];
      got.window_start    = out_tdata[15:8];
      got.view_row        = out_tdata[16];
      got.cursor_column   = out_tdata[22:17];
      got.fetched_char    = out_tdata[30:23];
      got.key_applied     = out_tdata[31];
      if (awaited_status.size() == 0) begin
        flag_mismatch("status word with none outstanding");
      end
      else begin
        want = awaited_status.pop_front();
        check_field("cursor_position", got.cursor_position, want.cursor_position);
        check_field("window_start", got.window_start, want.window_start);
        check_field("view_row", got.view_row, want.view_row);
        check_field("cursor_column", got.cursor_column, want.cursor_column);
        check_field("fetched_char", got.fetched_char, want.fetched_char);
        check_field("key_applied", got.key_applied, want.key_applied);
      end
      status_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end
    else if (quiet_cycles >= STALL_MAX) begin
      $display("[line_editor_with_cursor] ERROR");
      $finish;
    end
    else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mismatches      = 0;
    status_seen     = 0;
    quiet_cycles    = 0;
    caret           = 0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    for (int i = 0; i < DEPTH; i++) line_mem[i] = 8'd0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= 16'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_line();
    test_edit_keys();
    test_full_line();
    test_random_edits(450);
    test_back_to_back(150);
    in_tvalid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("[line_editor_with_cursor] OK");
    end
    else begin
      $display("[line_editor_with_cursor] ERROR");
    end
    $finish;
  end

endmodule
